FILE: rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/illm_pkg.sv
// ----------------------------------------------------------------------------
// illm_pkg
// Constants, codes and controller/datapath interface types of the linked
// list manager.
// ----------------------------------------------------------------------------
package illm_pkg;

  localparam int POOL_SIZE   = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(POOL_SIZE);
  localparam int NUM_W       = 11;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 2;
  localparam int ST_W        = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_HEAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_AFTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL_AFTER = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    LRD_K,
    LRD_HEAD,
    LRD_LINK
  } lrd_sel_e;

  typedef enum logic [1:0] {
    LWR_NEW_HEAD,
    LWR_NEW_LINK,
    LWR_K_NEW,
    LWR_K_LINK
  } lwr_sel_e;

  typedef enum logic {
    HD_NEW,
    HD_LINK
  } head_sel_e;

  typedef struct packed {
    logic      cap;
    logic      chk;
    logic      lrd_en;
    lrd_sel_e  lrd_sel;
    logic      vrd_en;
    logic      lwr_en;
    lwr_sel_e  lwr_sel;
    logic      vwr_en;
    logic      head_en;
    head_sel_e head_sel;
    logic      cnt_inc;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             k_zero;
    logic             k_too_big;
    logic             full;
    logic             head_zero;
    logic             link_zero;
    logic             out_free;
  } dp_stat_t;

endpackage

FILE: rtl/illm_ctrl.sv
// ----------------------------------------------------------------------------
// illm_ctrl
// Command sequencer: walks each command through its link memory reads and
// writes, then hands the result word to the output register.
// ----------------------------------------------------------------------------
module illm_ctrl
  import illm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t ctl_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_INS_A    = 3'd2;
  localparam logic [2:0] S_INS_B    = 3'd3;
  localparam logic [2:0] S_DEL_HEAD = 3'd4;
  localparam logic [2:0] S_DEL_Q    = 3'd5;
  localparam logic [2:0] S_DEL_WR   = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    ctl_o.cap      = 1'b0;
    ctl_o.chk      = 1'b0;
    ctl_o.lrd_en   = 1'b0;
    ctl_o.lrd_sel  = LRD_K;
    ctl_o.vrd_en   = 1'b0;
    ctl_o.lwr_en   = 1'b0;
    ctl_o.lwr_sel  = LWR_NEW_HEAD;
    ctl_o.vwr_en   = 1'b0;
    ctl_o.head_en  = 1'b0;
    ctl_o.head_sel = HD_NEW;
    ctl_o.cnt_inc  = 1'b0;
    ctl_o.out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl_o.chk = 1'b1;
        state_d   = S_RESP;
        if (!stat_i.k_too_big) begin
          if (stat_i.cmd inside {CMD_INS_HEAD, CMD_INS_AFTER}) begin
            if (!stat_i.full) begin
              if (stat_i.cmd == CMD_INS_HEAD || stat_i.k_zero) begin
                ctl_o.vwr_en   = 1'b1;
                ctl_o.lwr_en   = 1'b1;
                ctl_o.lwr_sel  = LWR_NEW_HEAD;
                ctl_o.head_en  = 1'b1;
                ctl_o.head_sel = HD_NEW;
                ctl_o.cnt_inc  = 1'b1;
              end else begin
                ctl_o.lrd_en = 1'b1;
                ctl_o.lrd_sel = LRD_K;
                state_d      = S_INS_A;
              end
            end
          end else if (stat_i.cmd == CMD_DEL_AFTER) begin
            if (stat_i.k_zero) begin
              if (!stat_i.head_zero) begin
                ctl_o.lrd_en  = 1'b1;
                ctl_o.lrd_sel = LRD_HEAD;
                state_d       = S_DEL_HEAD;
              end
            end else begin
              ctl_o.lrd_en  = 1'b1;
              ctl_o.lrd_sel = LRD_K;
              state_d       = S_DEL_Q;
            end
          end else if (!stat_i.k_zero) begin
            ctl_o.lrd_en  = 1'b1;
            ctl_o.lrd_sel = LRD_K;
            ctl_o.vrd_en  = 1'b1;
          end
        end
      end
      S_INS_A: begin
        // new node takes over the successor of node k
        ctl_o.vwr_en  = 1'b1;
        ctl_o.lwr_en  = 1'b1;
        ctl_o.lwr_sel = LWR_NEW_LINK;
        state_d       = S_INS_B;
      end
      S_INS_B: begin
        ctl_o.lwr_en  = 1'b1;
        ctl_o.lwr_sel = LWR_K_NEW;
        ctl_o.cnt_inc = 1'b1;
        state_d       = S_RESP;
      end
      S_DEL_HEAD: begin
        ctl_o.head_en  = 1'b1;
        ctl_o.head_sel = HD_LINK;
        state_d        = S_RESP;
      end
      S_DEL_Q: begin
        state_d = S_RESP;
        if (!stat_i.link_zero) begin
          ctl_o.lrd_en  = 1'b1;
          ctl_o.lrd_sel = LRD_LINK;
          state_d       = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        ctl_o.lwr_en  = 1'b1;
        ctl_o.lwr_sel = LWR_K_LINK;
        state_d       = S_RESP;
      end
      S_RESP: begin
        // hold until the output register can take the word
        if (stat_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/illm_datapath.sv
// ----------------------------------------------------------------------------
// illm_datapath
// Node value and link memories, head pointer, insert counter, command
// registers and the output register.
// ----------------------------------------------------------------------------
module illm_datapath
  import illm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [NUM_W-1:0]         node_number_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  ctl_cmd_t                 ctl_i,
  output dp_stat_t                 stat_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [NUM_W-1:0]         successor_o,
  output logic [NUM_W-1:0]         assigned_number_o
);

  logic [VALUE_WIDTH-1:0] node_values [POOL_SIZE];
  logic [NUM_W-1:0]       node_links  [POOL_SIZE];

  logic [CMD_W-1:0]       cmd_q;
  logic [NUM_W-1:0]       k_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [ST_W-1:0]        st_q;
  logic [NUM_W-1:0]       head_q, head_d;
  logic [NUM_W-1:0]       count_q;
  logic [NUM_W-1:0]       lrdata_q;
  logic [VALUE_WIDTH-1:0] vrdata_q;
  logic                   out_valid_q;

  logic [NUM_W-1:0]  k_m1, head_m1, link_m1, next_num;
  logic [ADDR_W-1:0] lraddr, lwaddr, k_addr, new_addr;
  logic [NUM_W-1:0]  lwdata;
  logic              is_insert, k_zero, k_too_big, full;
  logic [ST_W-1:0]   st_d;
  logic              st_ok, rd_hit;

  assign k_m1     = k_q - NUM_W'(1);
  assign head_m1  = head_q - NUM_W'(1);
  assign link_m1  = lrdata_q - NUM_W'(1);
  assign next_num = count_q + NUM_W'(1);
  assign k_addr   = k_m1[ADDR_W-1:0];
  assign new_addr = count_q[ADDR_W-1:0];

  assign is_insert = (cmd_q inside {CMD_INS_HEAD, CMD_INS_AFTER});
  assign k_zero    = (k_q == '0);
  assign k_too_big = (k_q > count_q);
  assign full      = (count_q == NUM_W'(POOL_SIZE));

  always_comb begin
    if (k_too_big) begin
      st_d = ST_RANGE;
    end else if (is_insert && full) begin
      st_d = ST_FULL;
    end else begin
      st_d = ST_OK;
    end
  end

  always_comb begin
    case (ctl_i.lrd_sel)
      LRD_K:    lraddr = k_addr;
      LRD_HEAD: lraddr = head_m1[ADDR_W-1:0];
      LRD_LINK: lraddr = link_m1[ADDR_W-1:0];
      default:  lraddr = k_addr;
    endcase
  end

  always_comb begin
    case (ctl_i.lwr_sel)
      LWR_NEW_HEAD: begin
        lwaddr = new_addr;
        lwdata = head_q;
      end
      LWR_NEW_LINK: begin
        lwaddr = new_addr;
        lwdata = lrdata_q;
      end
      LWR_K_NEW: begin
        lwaddr = k_addr;
        lwdata = next_num;
      end
      LWR_K_LINK: begin
        lwaddr = k_addr;
        lwdata = lrdata_q;
      end
      default: begin
        lwaddr = new_addr;
        lwdata = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.lwr_en) begin
      node_links[lwaddr] <= lwdata;
    end
    if (ctl_i.lrd_en) begin
      lrdata_q <= node_links[lraddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vwr_en) begin
      node_values[new_addr] <= val_q;
    end
    if (ctl_i.vrd_en) begin
      vrdata_q <= node_values[k_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q <= cmd_i;
      k_q   <= node_number_i;
      val_q <= value_i[VALUE_WIDTH-1:0];
    end
    if (ctl_i.chk) begin
      st_q <= st_d;
    end
  end

  assign head_d = (ctl_i.head_sel == HD_LINK) ? lrdata_q : next_num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      if (ctl_i.head_en) begin
        head_q <= head_d;
      end
      if (ctl_i.cnt_inc) begin
        count_q <= next_num;
      end
    end
  end

  assign st_ok  = (st_q == ST_OK);
  assign rd_hit = st_ok && (cmd_q == CMD_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      status_o          <= st_q;
      read_value_o      <= (rd_hit && !k_zero) ? DATA_W'($signed(vrdata_q)) : '0;
      successor_o       <= rd_hit ? (k_zero ? head_q : lrdata_q) : '0;
      // counter was already advanced, so it holds the new node's number
      assigned_number_o <= (st_ok && is_insert) ? count_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.cmd       = cmd_q;
  assign stat_o.k_zero    = k_zero;
  assign stat_o.k_too_big = k_too_big;
  assign stat_o.full      = full;
  assign stat_o.head_zero = (head_q == '0);
  assign stat_o.link_zero = (lrdata_q == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/indexed_linked_list_manager.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_manager
// Singly linked list held in a node pool, driven one command word at a time.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) takes a command word: cmd_i,
// node_number_i, value_i. Output channel (out_valid_o/out_ready_i) returns
// one result word per command: status_o, read_value_o, successor_o,
// assigned_number_o.
// One command is in work at a time. After acceptance each command passes
// through S_DECODE and S_RESP; before S_RESP an insert after a node also
// passes S_INS_A and S_INS_B, a delete after a node S_DEL_Q and S_DEL_WR,
// a delete after a node that has no successor S_DEL_Q, and a delete at the
// head S_DEL_HEAD. in_ready_o rises again in the cycle the result shows,
// so a new command is not taken until the last result is in the output
// register. The extra states are set by the link memory, which takes one
// read or one write per step: a delete after a node chains two link reads,
// and an insert after a node needs two link writes.
// When the receiver stalls, the finished word waits in the output register
// and the sequencer holds the next result until the register frees.
// Reset empties the list (head 0, insert count 0) and drops any pending
// word; the node memories are not cleared, since only written slots are
// ever read.
// ----------------------------------------------------------------------------
module indexed_linked_list_manager
  import illm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [NUM_W-1:0]         node_number_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [NUM_W-1:0]         successor_o,
  output logic [NUM_W-1:0]         assigned_number_o
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  illm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  illm_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd_i),
    .node_number_i     (node_number_i),
    .value_i           (value_i),
    .ctl_i             (ctl),
    .stat_o            (stat),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .read_value_o      (read_value_o),
    .successor_o       (successor_o),
    .assigned_number_o (assigned_number_o)
  );

endmodule

FILE: rtl/illm_checker.sv
// ----------------------------------------------------------------------------
// illm_checker
// Port-level checks of the linked list manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module illm_checker
  import illm_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [ST_W-1:0]          status_o,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [NUM_W-1:0]         successor_o,
  input logic [NUM_W-1:0]         assigned_number_o
);

  logic                              in_acc;
  logic                              err_word;
  logic                              out_stall;
  logic                              rd_data;
  logic [ST_W+DATA_W+2*NUM_W-1:0]    out_word;

  assign in_acc    = in_valid_i && in_ready_o;
  assign err_word  = out_valid_o && (status_o != ST_OK);
  assign out_stall = out_valid_o && !out_ready_i;
  assign rd_data   = (read_value_o != '0) || (successor_o != '0);
  assign out_word  = {status_o, read_value_o, successor_o, assigned_number_o};

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_word), "stalled word changed")

  // one command in work at a time
  `ASSERT_CLK(a_busy_after_acc, clk_i, rst_ni, in_acc |=> !in_ready_o, "command taken while busy")

  `ASSERT_NEVER(a_err_clean, clk_i, rst_ni, err_word && (rd_data || assigned_number_o != '0), "rejected word has data")

  `ASSERT_NEVER(a_insert_vs_read, clk_i, rst_ni, out_valid_o && (assigned_number_o != '0) && rd_data, "insert has read data")

  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, err_word && (status_o != ST_FULL) && (status_o != ST_RANGE), "undefined status code")

endmodule

bind indexed_linked_list_manager illm_checker u_illm_checker (.*);
